// File: hw/rtl/cln_pkg.sv
// cell list neighbor search: shared widths, codes, offset tables and types
// no dependencies
`timescale 1ns / 1ps

package cln_pkg;

    localparam int POS_W      = 31;
    localparam int LEN_W      = 30;
    localparam int IDX_W      = 10;
    localparam int D2_W       = 63;
    localparam int NCELL_W    = 7;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIR_W      = 4;

    localparam logic [DIR_W-1:0] DIR_HOME = 4'd0;
    localparam logic [DIR_W-1:0] DIR_LAST = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y     = 3'd5;

    // home cell first, then the eight neighbors
    function automatic logic signed [1:0] step_x(input logic [DIR_W-1:0] d);
        logic signed [1:0] s;
        case (d)
            4'd1, 4'd2, 4'd8: s = 2'sd1;
            4'd4, 4'd5, 4'd6: s = -2'sd1;
            default:          s = 2'sd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [1:0] step_y(input logic [DIR_W-1:0] d);
        logic signed [1:0] s;
        case (d)
            4'd2, 4'd3, 4'd4: s = 2'sd1;
            4'd6, 4'd7, 4'd8: s = -2'sd1;
            default:          s = 2'sd0;
        endcase
        return s;
    endfunction

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             busy;
        logic [IDX_W-1:0] idx;
    } dist_res_t;

endpackage

// File: hw/rtl/cln_ram.sv
// cell list neighbor search: simple dual port ram, registered read with enable
// no dependencies
`timescale 1ns / 1ps

module cln_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/cln_div.sv
// cell list neighbor search: restoring divider, one quotient bit per cycle
// depends on cln_pkg
`timescale 1ns / 1ps

module cln_div
    import cln_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             done,
    output logic [POS_W-1:0] quotient,
    output logic [LEN_W-1:0] remainder
);

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] work_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] dvs_reg;

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, work_reg[POS_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(POS_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[POS_W-2:0], ge};
            rem_reg  <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// File: hw/rtl/cln_dist.sv
// cell list neighbor search: distance pipeline, differences, squares, compare
// depends on cln_pkg
`timescale 1ns / 1ps

module cln_dist
    import cln_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic signed [POS_W-1:0] xi,
    input  logic signed [POS_W-1:0] yi,
    input  logic [LEN_W-1:0]        hi,
    input  logic signed [POS_W-1:0] xj,
    input  logic signed [POS_W-1:0] yj,
    input  logic [LEN_W-1:0]        hj,
    input  logic                    in_valid,
    input  logic                    in_self,
    input  logic [IDX_W-1:0]        in_idx,
    output dist_res_t               res,
    output logic [D2_W-1:0]         d2
);

    localparam int DF_W = POS_W + 1;
    localparam int SQ_W = 2 * POS_W;

    logic                   v3_reg;
    logic                   v4_reg;
    logic                   self3_reg;
    logic                   self4_reg;
    logic [IDX_W-1:0]       idx3_reg;
    logic [IDX_W-1:0]       idx4_reg;
    logic signed [DF_W-1:0] dx_reg;
    logic signed [DF_W-1:0] dy_reg;
    logic [LEN_W:0]         hs_reg;
    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [SQ_W-1:0]        hs2_reg;

    logic signed [DF_W-1:0] dx_next;
    logic signed [DF_W-1:0] dy_next;
    logic [DF_W-1:0]        ax;
    logic [DF_W-1:0]        ay;

    always_comb
    begin
        dx_next = DF_W'(xj) - DF_W'(xi);
        dy_next = DF_W'(yj) - DF_W'(yi);
        ax      = dx_reg[DF_W-1] ? DF_W'(-dx_reg) : DF_W'(dx_reg);
        ay      = dy_reg[DF_W-1] ? DF_W'(-dy_reg) : DF_W'(dy_reg);
        d2      = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            self3_reg <= in_self;
            idx3_reg  <= in_idx;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            hs_reg    <= (LEN_W + 1)'(hi) + (LEN_W + 1)'(hj);
            self4_reg <= self3_reg;
            idx4_reg  <= idx3_reg;
            sqx_reg   <= ax[POS_W-1:0] * ax[POS_W-1:0];
            sqy_reg   <= ay[POS_W-1:0] * ay[POS_W-1:0];
            hs2_reg   <= hs_reg * hs_reg;
        end
    end

    always_comb
    begin
        res.valid = v4_reg;
        res.hit   = v4_reg && !self4_reg && (d2 <= D2_W'(hs2_reg));
        res.busy  = v3_reg || v4_reg;
        res.idx   = idx4_reg;
    end

endmodule

// File: hw/rtl/cell_list_neighbor_search.sv
// Two-dimensional particle neighbor search over a uniform cell grid.
// Requests: clear empties every cell (one fill count entry per cycle);
// load runs two passes of the shared divider that finds the cell column
// and row; query decodes the home cell with the divider, then for each
// in-grid cell reads its fill count and then each stored member from the
// member list port, skips each cell off the grid, and finally drains the
// distance pipeline and answers. A stalled result output holds the scan.
// After reset a clearing pass over all MAX_CELLS cells runs before the
// first request is taken; configuration writes are taken at any time.
// Results leave through an output register.
// Depends on cln_pkg, cln_ram, cln_div, cln_dist.
`timescale 1ns / 1ps

module cell_list_neighbor_search
    import cln_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_CELLS     = 4096,
    parameter int CELL_CAPACITY = 32,
    parameter int MAX_NEIGHBORS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        command,
    input  logic [IDX_W-1:0]        particle_index,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic [LEN_W-1:0]        smoothing_length,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STAT_W-1:0]       status,
    output logic                    neighbor_valid,
    output logic [IDX_W-1:0]        neighbor_index,
    output logic [D2_W-1:0]         distance_squared,
    output logic                    truncated,
    output logic                    last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CA_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int PA_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int LA_W  = (MAX_CELLS * CELL_CAPACITY > 1) ?
                           $clog2(MAX_CELLS * CELL_CAPACITY) : 1;
    localparam int FC_W  = $clog2(CELL_CAPACITY + 1);
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
    localparam int CX_W  = (CA_W > NCELL_W) ? CA_W : NCELL_W;
    localparam int TX_W  = CX_W + 2;
    localparam int TY_W  = NCELL_W + 2;
    localparam int PR_W  = TX_W + NCELL_W + 1;
    localparam int LC_W  = 2 * NCELL_W;
    localparam int PM_W  = 2 * POS_W + LEN_W + CA_W;

    typedef enum logic [14:0] {
        S_SWEEP  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_LDX    = 15'b000000000000100,
        S_LDY    = 15'b000000000001000,
        S_LCELL  = 15'b000000000010000,
        S_LFILL  = 15'b000000000100000,
        S_RESP   = 15'b000000001000000,
        S_QREAD  = 15'b000000010000000,
        S_QHOME  = 15'b000000100000000,
        S_QDIV   = 15'b000001000000000,
        S_QCELL  = 15'b000010000000000,
        S_QFILL  = 15'b000100000000000,
        S_QISSUE = 15'b001000000000000,
        S_QDRAIN = 15'b010000000000000,
        S_QLAST  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [POS_W-1:0] origin_x_reg;
    logic signed [POS_W-1:0] origin_y_reg;
    logic [LEN_W-1:0]        cell_w_reg;
    logic [LEN_W-1:0]        cell_h_reg;
    logic [NCELL_W-1:0]      cells_x_reg;
    logic [NCELL_W-1:0]      cells_y_reg;

    logic [CA_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              clr_resp_reg, clr_resp_next;
    logic              v1_reg, v1_next;
    logic              v2_reg;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              trunc_reg, trunc_next;
    logic              out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]        pi_reg, pi_next;
    logic signed [POS_W-1:0] px_reg, px_next;
    logic signed [POS_W-1:0] py_reg, py_next;
    logic [LEN_W-1:0]        h_reg, h_next;
    logic [POS_W-1:0]        offy_reg, offy_next;
    logic [POS_W-1:0]        xi_reg, xi_next;
    logic [POS_W-1:0]        yi_reg, yi_next;
    logic [CA_W-1:0]         cell_reg, cell_next;
    logic [STAT_W-1:0]       resp_reg, resp_next;
    logic [CA_W-1:0]         home_reg, home_next;
    logic signed [POS_W-1:0] qx_reg, qx_next;
    logic signed [POS_W-1:0] qy_reg, qy_next;
    logic [LEN_W-1:0]        qh_reg, qh_next;
    logic [CX_W-1:0]         cx_reg, cx_next;
    logic [NCELL_W-1:0]      cy_reg, cy_next;
    logic [DIR_W-1:0]        dir_reg, dir_next;
    logic [FC_W-1:0]         n_reg, n_next;
    logic [FC_W-1:0]         k_reg, k_next;
    logic [IDX_W-1:0]        j2_reg;
    logic                    self2_reg;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [D2_W-1:0]         pend_d2_reg, pend_d2_next;

    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic              out_nvalid_reg, out_nvalid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [D2_W-1:0]   out_d2_reg, out_d2_next;
    logic              out_trunc_reg, out_trunc_next;
    logic              out_last_reg, out_last_next;

    logic [NCELL_W-1:0] nx;
    logic [NCELL_W-1:0] ny;
    logic [LEN_W-1:0]   wdiv;
    logic [LEN_W-1:0]   hdiv;
    logic signed [POS_W:0] off_x;
    logic signed [POS_W:0] off_y;
    logic               in_fire;
    logic               pi_bad;
    logic               out_free;
    logic               adv;
    logic               iss;

    logic [LC_W-1:0]        lcell;
    logic                   l_bad;
    logic signed [TX_W-1:0] tx_s;
    logic signed [TY_W-1:0] ty_s;
    logic [PR_W-1:0]        qprod;
    logic                   q_skip;
    logic [CA_W-1:0]        qcell;

    logic             div_start;
    logic [POS_W-1:0] div_dividend;
    logic [LEN_W-1:0] div_divisor;
    logic             div_done;
    logic [POS_W-1:0] div_q;
    logic [LEN_W-1:0] div_r;

    logic             fill_wr_en;
    logic [CA_W-1:0]  fill_wr_addr;
    logic [FC_W-1:0]  fill_wr_data;
    logic [CA_W-1:0]  fill_rd_addr;
    logic [FC_W-1:0]  fill_rd_data;

    logic             list_wr_en;
    logic [LA_W-1:0]  list_wr_addr;
    logic [LA_W-1:0]  list_rd_addr;
    logic [IDX_W-1:0] list_rd_data;

    logic             pm_wr_en;
    logic [PA_W-1:0]  pm_rd_addr;
    logic [PM_W-1:0]  pm_wr_data;
    logic [PM_W-1:0]  pm_rd_data;

    dist_res_t        res;
    logic [D2_W-1:0]  res_d2;

    // grid setup
    always_comb
    begin
        nx    = (cells_x_reg == '0) ? NCELL_W'(1) : cells_x_reg;
        ny    = (cells_y_reg == '0) ? NCELL_W'(1) : cells_y_reg;
        wdiv  = (cell_w_reg == '0) ? LEN_W'(1) : cell_w_reg;
        hdiv  = (cell_h_reg == '0) ? LEN_W'(1) : cell_h_reg;
        off_x = (POS_W + 1)'(pos_x) - (POS_W + 1)'(origin_x_reg);
        off_y = (POS_W + 1)'(pos_y) - (POS_W + 1)'(origin_y_reg);
        pi_bad = 32'(particle_index) >= 32'(MAX_PARTICLES);
        in_ready = (state_reg == S_IDLE);
        in_fire  = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        adv      = !(res.valid && pend_valid_reg && !out_free);
        iss      = (state_reg == S_QISSUE);
    end

    // load cell number
    always_comb
    begin
        lcell = LC_W'(xi_reg[NCELL_W-1:0]) * LC_W'(ny) + LC_W'(yi_reg[NCELL_W-1:0]);
        l_bad = (xi_reg >= POS_W'(nx)) || (yi_reg >= POS_W'(ny)) ||
                (32'(lcell) >= 32'(MAX_CELLS));
    end

    // query neighbor cell
    always_comb
    begin
        tx_s   = $signed({2'b00, cx_reg}) + TX_W'(step_x(dir_reg));
        ty_s   = $signed({2'b00, cy_reg}) + TY_W'(step_y(dir_reg));
        qprod  = PR_W'(tx_s[TX_W-2:0]) * PR_W'(ny) + PR_W'(ty_s[TY_W-2:0]);
        q_skip = (dir_reg != DIR_HOME) &&
                 (tx_s[TX_W-1] || ty_s[TY_W-1] ||
                  (tx_s[TX_W-2:0] >= (TX_W - 1)'(nx)) ||
                  (ty_s[TY_W-2:0] >= (TY_W - 1)'(ny)) ||
                  (32'(qprod) >= 32'(MAX_CELLS)));
        qcell  = (dir_reg == DIR_HOME) ? home_reg : CA_W'(qprod);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_resp_next   = clr_resp_reg;
        v1_next         = iss;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        trunc_next      = trunc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pi_next         = pi_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        h_next          = h_reg;
        offy_next       = offy_reg;
        xi_next         = xi_reg;
        yi_next         = yi_reg;
        cell_next       = cell_reg;
        resp_next       = resp_reg;
        home_next       = home_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qh_next         = qh_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        dir_next        = dir_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        pend_idx_next   = pend_idx_reg;
        pend_d2_next    = pend_d2_reg;
        out_status_next = out_status_reg;
        out_nvalid_next = out_nvalid_reg;
        out_idx_next    = out_idx_reg;
        out_d2_next     = out_d2_reg;
        out_trunc_next  = out_trunc_reg;
        out_last_next   = out_last_reg;

        div_start    = 1'b0;
        div_dividend = off_x[POS_W-1:0];
        div_divisor  = wdiv;
        fill_wr_en   = 1'b0;
        fill_wr_addr = cell_reg;
        fill_wr_data = FC_W'(fill_rd_data + 1'b1);
        fill_rd_addr = qcell;
        list_wr_en   = 1'b0;
        pm_wr_en     = 1'b0;

        unique case (state_reg)
            S_SWEEP:
            begin
                fill_wr_en   = 1'b1;
                fill_wr_addr = clr_cnt_reg;
                fill_wr_data = '0;
                clr_cnt_next = CA_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == CA_W'(MAX_CELLS - 1))
                begin
                    clr_cnt_next  = '0;
                    clr_resp_next = 1'b0;
                    resp_next     = ST_OK;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pi_next   = particle_index;
                    px_next   = pos_x;
                    py_next   = pos_y;
                    h_next    = smoothing_length;
                    offy_next = off_y[POS_W-1:0];
                    resp_next = ST_OK;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            clr_resp_next = 1'b1;
                            state_next    = S_SWEEP;
                        end
                        CMD_LOAD:
                        begin
                            if (pi_bad || off_x[POS_W] || off_y[POS_W])
                            begin
                                resp_next  = ST_OUTSIDE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_LDX;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (pi_bad)
                            begin
                                resp_next  = ST_OUTSIDE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_QREAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_LDX:
            begin
                div_dividend = offy_reg;
                div_divisor  = hdiv;
                if (div_done)
                begin
                    xi_next    = div_q;
                    div_start  = 1'b1;
                    state_next = S_LDY;
                end
            end
            S_LDY:
            begin
                if (div_done)
                begin
                    yi_next    = div_q;
                    state_next = S_LCELL;
                end
            end
            S_LCELL:
            begin
                fill_rd_addr = CA_W'(lcell);
                cell_next    = CA_W'(lcell);
                if (l_bad)
                begin
                    resp_next  = ST_OUTSIDE;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_LFILL;
                end
            end
            S_LFILL:
            begin
                state_next = S_RESP;
                if (32'(fill_rd_data) >= 32'(CELL_CAPACITY))
                begin
                    resp_next = ST_FULL;
                end
                else
                begin
                    fill_wr_en = 1'b1;
                    list_wr_en = 1'b1;
                    pm_wr_en   = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_nvalid_next = 1'b0;
                    out_idx_next    = '0;
                    out_d2_next     = '0;
                    out_trunc_next  = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_QREAD:
            begin
                state_next = S_QHOME;
            end
            S_QHOME:
            begin
                qx_next         = pm_rd_data[POS_W-1:0];
                qy_next         = pm_rd_data[2*POS_W-1:POS_W];
                qh_next         = pm_rd_data[2*POS_W+LEN_W-1:2*POS_W];
                home_next       = pm_rd_data[PM_W-1 -: CA_W];
                div_start       = 1'b1;
                div_dividend    = POS_W'(pm_rd_data[PM_W-1 -: CA_W]);
                div_divisor     = LEN_W'(ny);
                count_next      = '0;
                trunc_next      = 1'b0;
                pend_valid_next = 1'b0;
                state_next      = S_QDIV;
            end
            S_QDIV:
            begin
                if (div_done)
                begin
                    cx_next    = div_q[CX_W-1:0];
                    cy_next    = div_r[NCELL_W-1:0];
                    dir_next   = DIR_HOME;
                    state_next = S_QCELL;
                end
            end
            S_QCELL:
            begin
                cell_next = qcell;
                if (q_skip)
                begin
                    dir_next   = DIR_W'(dir_reg + 1'b1);
                    state_next = (dir_reg == DIR_LAST) ? S_QDRAIN : S_QCELL;
                end
                else
                begin
                    state_next = S_QFILL;
                end
            end
            S_QFILL:
            begin
                n_next = fill_rd_data;
                k_next = '0;
                if (fill_rd_data == '0)
                begin
                    dir_next   = DIR_W'(dir_reg + 1'b1);
                    state_next = (dir_reg == DIR_LAST) ? S_QDRAIN : S_QCELL;
                end
                else
                begin
                    state_next = S_QISSUE;
                end
            end
            S_QISSUE:
            begin
                if (adv)
                begin
                    k_next = FC_W'(k_reg + 1'b1);
                    if (FC_W'(k_reg + 1'b1) == n_reg)
                    begin
                        dir_next   = DIR_W'(dir_reg + 1'b1);
                        state_next = (dir_reg == DIR_LAST) ? S_QDRAIN : S_QCELL;
                    end
                end
            end
            S_QDRAIN:
            begin
                if (!v1_reg && !v2_reg && !res.busy)
                begin
                    state_next = S_QLAST;
                end
            end
            S_QLAST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_nvalid_next = pend_valid_reg;
                    out_idx_next    = pend_valid_reg ? pend_idx_reg : '0;
                    out_d2_next     = pend_valid_reg ? pend_d2_reg : '0;
                    out_trunc_next  = trunc_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // neighbor found at the end of the distance pipeline
        if (adv && res.hit)
        begin
            if (count_reg < CNT_W'(MAX_NEIGHBORS))
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_nvalid_next = 1'b1;
                    out_idx_next    = pend_idx_reg;
                    out_d2_next     = pend_d2_reg;
                    out_trunc_next  = 1'b0;
                    out_last_next   = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = res.idx;
                pend_d2_next    = res_d2;
                count_next      = CNT_W'(count_reg + 1'b1);
            end
            else
            begin
                trunc_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        list_wr_addr = LA_W'(cell_reg) * LA_W'(CELL_CAPACITY) + LA_W'(fill_rd_data);
        list_rd_addr = LA_W'(cell_reg) * LA_W'(CELL_CAPACITY) + LA_W'(k_reg);
        pm_rd_addr   = (state_reg == S_QREAD) ? PA_W'(pi_reg) : PA_W'(list_rd_data);
        pm_wr_data   = {cell_reg, h_reg, py_reg, px_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cell_w_reg     <= LEN_W'(65536);
            cell_h_reg     <= LEN_W'(65536);
            cells_x_reg    <= NCELL_W'(64);
            cells_y_reg    <= NCELL_W'(64);
            clr_cnt_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            trunc_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_resp_reg   <= clr_resp_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            trunc_reg      <= trunc_next;
            out_valid_reg  <= out_valid_next;
            if (adv)
            begin
                v1_reg <= v1_next;
                v2_reg <= v1_reg;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:    origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y:    origin_y_reg <= cfg_data;
                    CFG_CELL_WIDTH:  cell_w_reg   <= cfg_data[LEN_W-1:0];
                    CFG_CELL_HEIGHT: cell_h_reg   <= cfg_data[LEN_W-1:0];
                    CFG_CELLS_X:     cells_x_reg  <= cfg_data[NCELL_W-1:0];
                    CFG_CELLS_Y:     cells_y_reg  <= cfg_data[NCELL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg         <= pi_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        h_reg          <= h_next;
        offy_reg       <= offy_next;
        xi_reg         <= xi_next;
        yi_reg         <= yi_next;
        cell_reg       <= cell_next;
        resp_reg       <= resp_next;
        home_reg       <= home_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        qh_reg         <= qh_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        dir_reg        <= dir_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        pend_idx_reg   <= pend_idx_next;
        pend_d2_reg    <= pend_d2_next;
        out_status_reg <= out_status_next;
        out_nvalid_reg <= out_nvalid_next;
        out_idx_reg    <= out_idx_next;
        out_d2_reg     <= out_d2_next;
        out_trunc_reg  <= out_trunc_next;
        out_last_reg   <= out_last_next;
        if (adv)
        begin
            j2_reg    <= list_rd_data;
            self2_reg <= (list_rd_data == pi_reg);
        end
    end

    cln_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // fill count per cell
    cln_ram #(
        .DEPTH (MAX_CELLS),
        .WIDTH (FC_W)
    ) u_fill (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (1'b1),
        .rd_addr (fill_rd_addr),
        .rd_data (fill_rd_data)
    );

    // member list, CELL_CAPACITY slots per cell
    cln_ram #(
        .DEPTH (MAX_CELLS * CELL_CAPACITY),
        .WIDTH (IDX_W)
    ) u_list (
        .clk     (clk),
        .wr_en   (list_wr_en),
        .wr_addr (list_wr_addr),
        .wr_data (pi_reg),
        .rd_en   (adv),
        .rd_addr (list_rd_addr),
        .rd_data (list_rd_data)
    );

    // particle position, smoothing length and home cell
    cln_ram #(
        .DEPTH (MAX_PARTICLES),
        .WIDTH (PM_W)
    ) u_part (
        .clk     (clk),
        .wr_en   (pm_wr_en),
        .wr_addr (PA_W'(pi_reg)),
        .wr_data (pm_wr_data),
        .rd_en   (adv),
        .rd_addr (pm_rd_addr),
        .rd_data (pm_rd_data)
    );

    cln_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .xi       (qx_reg),
        .yi       (qy_reg),
        .hi       (qh_reg),
        .xj       (pm_rd_data[POS_W-1:0]),
        .yj       (pm_rd_data[2*POS_W-1:POS_W]),
        .hj       (pm_rd_data[2*POS_W+LEN_W-1:2*POS_W]),
        .in_valid (v2_reg),
        .in_self  (self2_reg),
        .in_idx   (j2_reg),
        .res      (res),
        .d2       (res_d2)
    );

    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign neighbor_valid   = out_nvalid_reg;
    assign neighbor_index   = out_idx_reg;
    assign distance_squared = out_d2_reg;
    assign truncated        = out_trunc_reg;
    assign last             = out_last_reg;

endmodule
